FILE: hdl/swie_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swie_pkg
// Types, constants and small arithmetic helpers shared by the shallow-water
// interface eigensystem pipeline and its divider.
// ----------------------------------------------------------------------------
package swie_pkg;

  localparam int CFG_W  = 31;
  localparam int ADDR_W = 1;

  localparam logic [ADDR_W-1:0] REG_GRAVITY   = 1'b0;
  localparam logic [ADDR_W-1:0] REG_FLOW_AXIS = 1'b1;

  localparam logic [CFG_W-1:0] GRAVITY_RST = 31'd642908;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q   = 32'sh0001_0000;

  localparam int DIV1_NW  = 48;
  localparam int DIV1_DW  = 32;
  localparam int DIV2_NW  = 49;
  localparam int DIV2_DW  = 33;
  localparam int SQ_STEPS = 31;
  localparam int SQ_PAD   = DIV1_NW - SQ_STEPS - 1;

  localparam logic signed [DIV2_NW-1:0] NUM_POS = 49'sh1_0000_0000;
  localparam logic signed [DIV2_NW-1:0] NUM_NEG = -NUM_POS;

  localparam int ST_C = 0;
  localparam int ST_L = 1;
  localparam int ST_R = 2;

  typedef struct packed {
    logic signed [31:0] left_depth;
    logic signed [31:0] left_momentum_x;
    logic signed [31:0] left_momentum_y;
    logic signed [31:0] right_depth;
    logic signed [31:0] right_momentum_x;
    logic signed [31:0] right_momentum_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] l_col0;
    logic signed [31:0] l_col1;
    logic signed [31:0] l_col2;
    logic signed [31:0] r_col0;
    logic signed [31:0] r_col1;
    logic signed [31:0] r_col2;
    logic signed [31:0] lambda_center;
    logic signed [31:0] lambda_left;
    logic signed [31:0] lambda_right;
    logic               hyperbolic;
    logic               degenerate;
    logic               last_row;
  } out_beat_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [30:0] root;
  } sq_t;

  typedef struct packed {
    logic [30:0] cc;
    logic [30:0] cl;
    logic [30:0] cr;
  } cel_t;

  typedef struct packed {
    logic lh_neg;
    logic rh_neg;
    logic ch_neg;
    logic ch_le0;
    logic axis;
  } sb1_t;

  typedef struct packed {
    logic [2:0][31:0] lm;
    logic [2:0][31:0] lp;
    logic [2:0][31:0] uu;
    logic [31:0]      r0nc;
    logic [31:0]      r2nc;
    logic [31:0]      ut;
    logic [31:0]      l10;
    logic             degc;
    logic             hyp;
    logic             sat;
    logic             axis;
  } sb2_t;

  function automatic sat_t sat34(input logic signed [33:0] v);
    sat_t s;
    logic fits;
    fits  = (v[33:31] == 3'b000) || (v[33:31] == 3'b111);
    s.ovf = !fits;
    s.val = fits ? v[31:0] : (v[33] ? S32_MIN : S32_MAX);
    return s;
  endfunction

  function automatic sq_t sq_step(input sq_t s, input logic [1:0] pair);
    sq_t         r;
    logic [34:0] trial;
    logic [32:0] t;
    trial = {s.rem, pair};
    t     = {s.root, 2'b01};
    if (trial >= {2'b00, t}) begin
      r.rem  = 33'(trial - {2'b00, t});
      r.root = {s.root[29:0], 1'b1};
    end else begin
      r.rem  = trial[32:0];
      r.root = {s.root[29:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: hdl/shallow_water_interface_eigensystem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_interface_eigensystem
// Characteristic decomposition of the shallow-water equations at the interface
// between two cells: eigenvector rows and wave speeds, saturating Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per interface, both cell states (depth, x/y momentum).
//   out_* : SPACE_DIMS+1 beats per interface, one per characteristic row,
//           last_row marks the final one.
//   cfg_* : write gravity (index 0) or flow axis (index 1) while idle.
// Path: the first row of an interface passes through an input stage, a
//   48-stage divider bank, two stages of wave-speed arithmetic, a 49-stage
//   divider bank and the row buffer.
// Throughput: set by the single result port, which sends one row per cycle
//   while out_ready is high. The pipeline accepts a beat every cycle while
//   the row buffer drains, as long as the tail stage holds no waiting item.
// Reset: clears all valid bits and the row buffer index (not the row data),
//   restores gravity to 9.81 and the flow axis to x.
// Stall: the pipeline holds while the row buffer is busy and the tail stage
//   holds a waiting item; nothing is lost or repeated, and in_ready drops then.
// ----------------------------------------------------------------------------
module shallow_water_interface_eigensystem #(
  parameter int SPACE_DIMS = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  swie_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output swie_pkg::out_beat_t           out_data,
  input  logic                          cfg_we,
  input  logic [swie_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [swie_pkg::CFG_W-1:0]    cfg_wdata
);
  import swie_pkg::*;

  localparam int NCOMP = SPACE_DIMS + 1;
  localparam int ROW_W = $clog2(NCOMP);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NCOMP - 1);

  logic [CFG_W-1:0] gravity_r;
  logic             flow_axis_r;
  logic             en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r   <= GRAVITY_RST;
      flow_axis_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRAVITY:   gravity_r   <= cfg_wdata;
        REG_FLOW_AXIS: flow_axis_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stage A: interface averages
  logic signed [31:0] a_lh_r, a_rh_r, a_ch_r, a_cn_r, a_ct_r, a_ml_r, a_mr_r;
  logic signed [31:0] a_ch_nxt, a_cn_nxt, a_ct_nxt, a_ml_nxt, a_mr_nxt;
  logic               a_axis_r, a_axis_nxt, a_v_r;

  always_comb begin
    logic signed [31:0] lmy, rmy;
    logic signed [32:0] sh, sx, sy;
    a_axis_nxt = (SPACE_DIMS >= 2) ? flow_axis_r : 1'b0;
    lmy = (SPACE_DIMS >= 2) ? in_data.left_momentum_y  : '0;
    rmy = (SPACE_DIMS >= 2) ? in_data.right_momentum_y : '0;
    sh  = {in_data.left_depth[31], in_data.left_depth}
        + {in_data.right_depth[31], in_data.right_depth};
    sx  = {in_data.left_momentum_x[31], in_data.left_momentum_x}
        + {in_data.right_momentum_x[31], in_data.right_momentum_x};
    sy  = {lmy[31], lmy} + {rmy[31], rmy};
    a_ch_nxt = sh[32:1];
    a_cn_nxt = a_axis_nxt ? sy[32:1] : sx[32:1];
    a_ct_nxt = a_axis_nxt ? sx[32:1] : sy[32:1];
    a_ml_nxt = a_axis_nxt ? lmy : in_data.left_momentum_x;
    a_mr_nxt = a_axis_nxt ? rmy : in_data.right_momentum_x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_lh_r   <= in_data.left_depth;
      a_rh_r   <= in_data.right_depth;
      a_ch_r   <= a_ch_nxt;
      a_cn_r   <= a_cn_nxt;
      a_ct_r   <= a_ct_nxt;
      a_ml_r   <= a_ml_nxt;
      a_mr_r   <= a_mr_nxt;
      a_axis_r <= a_axis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  // velocities
  sat_t q_ul, q_ur, q_un, q_ut;

  swie_div #(.NW(DIV1_NW), .DW(DIV1_DW)) u_div_ul (
    .clk(clk), .en(en), .num_i({a_ml_r, 16'h0}), .den_i(a_lh_r), .quo_o(q_ul)
  );
  swie_div #(.NW(DIV1_NW), .DW(DIV1_DW)) u_div_ur (
    .clk(clk), .en(en), .num_i({a_mr_r, 16'h0}), .den_i(a_rh_r), .quo_o(q_ur)
  );
  swie_div #(.NW(DIV1_NW), .DW(DIV1_DW)) u_div_un (
    .clk(clk), .en(en), .num_i({a_cn_r, 16'h0}), .den_i(a_ch_r), .quo_o(q_un)
  );

  generate
    if (SPACE_DIMS >= 2) begin : g_ut
      swie_div #(.NW(DIV1_NW), .DW(DIV1_DW)) u_div_ut (
        .clk(clk), .en(en), .num_i({a_ct_r, 16'h0}), .den_i(a_ch_r), .quo_o(q_ut)
      );
    end else begin : g_no_ut
      assign q_ut = '{ovf: 1'b0, val: '0};
    end
  endgenerate

  // celerities: product, then digit-by-digit square root
  logic [61:0] m_x_r   [3];
  logic [61:0] m_x_nxt [3];
  sq_t         sq_r    [3][SQ_STEPS];
  sq_t         sq_nxt  [3][SQ_STEPS];
  logic [61:0] xs_r    [3][SQ_STEPS-1];
  logic [61:0] xs_nxt  [3][SQ_STEPS-1];
  cel_t        pad_r   [SQ_PAD];
  cel_t        pad_nxt [SQ_PAD];

  always_comb begin
    logic signed [31:0] h [3];
    h[ST_C] = a_ch_r;
    h[ST_L] = a_lh_r;
    h[ST_R] = a_rh_r;
    for (int u = 0; u < 3; u++) begin
      m_x_nxt[u] = (!h[u][31] && (h[u] != '0)) ? gravity_r * h[u][30:0] : '0;
      sq_nxt[u][0] = sq_step('{rem: '0, root: '0}, m_x_r[u][61:60]);
      xs_nxt[u][0] = m_x_r[u] << 2;
      for (int j = 1; j < SQ_STEPS; j++) begin
        sq_nxt[u][j] = sq_step(sq_r[u][j-1], xs_r[u][j-1][61:60]);
        if (j < SQ_STEPS - 1) begin
          xs_nxt[u][j] = xs_r[u][j-1] << 2;
        end
      end
    end
    pad_nxt[0].cc = sq_r[ST_C][SQ_STEPS-1].root;
    pad_nxt[0].cl = sq_r[ST_L][SQ_STEPS-1].root;
    pad_nxt[0].cr = sq_r[ST_R][SQ_STEPS-1].root;
    for (int p = 1; p < SQ_PAD; p++) begin
      pad_nxt[p] = pad_r[p-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_x_r <= m_x_nxt;
      sq_r  <= sq_nxt;
      xs_r  <= xs_nxt;
      pad_r <= pad_nxt;
    end
  end

  // sideband alongside the first divider bank
  sb1_t s1_r   [DIV1_NW];
  sb1_t s1_nxt [DIV1_NW];
  logic v1_r   [DIV1_NW];

  always_comb begin
    s1_nxt[0].lh_neg = a_lh_r[31];
    s1_nxt[0].rh_neg = a_rh_r[31];
    s1_nxt[0].ch_neg = a_ch_r[31];
    s1_nxt[0].ch_le0 = a_ch_r[31] || (a_ch_r == '0);
    s1_nxt[0].axis   = a_axis_r;
    for (int i = 1; i < DIV1_NW; i++) begin
      s1_nxt[i] = s1_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV1_NW; i++) begin
        v1_r[i] <= 1'b0;
      end
    end else if (en) begin
      v1_r[0] <= a_v_r;
      for (int i = 1; i < DIV1_NW; i++) begin
        v1_r[i] <= v1_r[i-1];
      end
    end
  end

  // stage B: gather velocities and celerities
  sat_t b_ul_r, b_ur_r, b_un_r, b_ut_r;
  cel_t b_cel_r;
  sb1_t b_sb_r;
  logic b_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_ul_r  <= q_ul;
      b_ur_r  <= q_ur;
      b_un_r  <= q_un;
      b_ut_r  <= q_ut;
      b_cel_r <= pad_r[SQ_PAD-1];
      b_sb_r  <= s1_r[DIV1_NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= v1_r[DIV1_NW-1];
    end
  end

  // stage C: wave speeds, right eigenvectors, L numerators
  sb2_t                      c_sb_r, c_sb_nxt;
  logic signed [DIV2_NW-1:0] c_num00_r, c_num00_nxt, c_num20_r, c_num20_nxt;
  logic signed [DIV2_DW-1:0] c_den_r, c_den_nxt;
  logic                      c_v_r;

  always_comb begin
    logic signed [31:0] u   [3];
    logic [30:0]        c   [3];
    logic               neg [3];
    sat_t               dm, dp, r0, r2, l10;
    logic               sat;
    logic signed [32:0] s00, s20;
    u[ST_C]   = b_un_r.val;
    u[ST_L]   = b_ul_r.val;
    u[ST_R]   = b_ur_r.val;
    c[ST_C]   = b_cel_r.cc;
    c[ST_L]   = b_cel_r.cl;
    c[ST_R]   = b_cel_r.cr;
    neg[ST_C] = b_sb_r.ch_neg;
    neg[ST_L] = b_sb_r.lh_neg;
    neg[ST_R] = b_sb_r.rh_neg;
    sat = b_ul_r.ovf | b_ur_r.ovf | b_un_r.ovf | b_ut_r.ovf;
    for (int s = 0; s < 3; s++) begin
      dm = sat34({{2{u[s][31]}}, u[s]} - {3'b000, c[s]});
      dp = sat34({{2{u[s][31]}}, u[s]} + {3'b000, c[s]});
      c_sb_nxt.lm[s] = neg[s] ? u[s] : dm.val;
      c_sb_nxt.lp[s] = neg[s] ? u[s] : dp.val;
      c_sb_nxt.uu[s] = u[s];
      sat = sat | (!neg[s] & (dm.ovf | dp.ovf));
    end
    r0  = sat34({{2{b_un_r.val[31]}}, b_un_r.val} - {3'b000, b_cel_r.cc});
    r2  = sat34({{2{b_un_r.val[31]}}, b_un_r.val} + {3'b000, b_cel_r.cc});
    l10 = sat34(-{{2{b_ut_r.val[31]}}, b_ut_r.val});
    c_sb_nxt.r0nc = r0.val;
    c_sb_nxt.r2nc = r2.val;
    c_sb_nxt.ut   = b_ut_r.val;
    c_sb_nxt.l10  = l10.val;
    c_sb_nxt.degc = b_sb_r.ch_le0 || (b_cel_r.cc == '0);
    c_sb_nxt.hyp  = !(b_sb_r.lh_neg || b_sb_r.rh_neg || b_sb_r.ch_neg);
    c_sb_nxt.sat  = sat | r0.ovf | r2.ovf | ((SPACE_DIMS >= 2) & l10.ovf);
    c_sb_nxt.axis = b_sb_r.axis;
    s00 = {b_un_r.val[31], b_un_r.val} + {2'b00, b_cel_r.cc};
    s20 = {2'b00, b_cel_r.cc} - {b_un_r.val[31], b_un_r.val};
    c_num00_nxt = {s00, 16'h0};
    c_num20_nxt = {s20, 16'h0};
    c_den_nxt   = {1'b0, b_cel_r.cc, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sb_r    <= c_sb_nxt;
      c_num00_r <= c_num00_nxt;
      c_num20_r <= c_num20_nxt;
      c_den_r   <= c_den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  // left eigenvector quotients
  sat_t q_l00, q_l20, q_lneg, q_lpos;

  swie_div #(.NW(DIV2_NW), .DW(DIV2_DW)) u_div_l00 (
    .clk(clk), .en(en), .num_i(c_num00_r), .den_i(c_den_r), .quo_o(q_l00)
  );
  swie_div #(.NW(DIV2_NW), .DW(DIV2_DW)) u_div_l20 (
    .clk(clk), .en(en), .num_i(c_num20_r), .den_i(c_den_r), .quo_o(q_l20)
  );
  swie_div #(.NW(DIV2_NW), .DW(DIV2_DW)) u_div_lneg (
    .clk(clk), .en(en), .num_i(NUM_NEG), .den_i(c_den_r), .quo_o(q_lneg)
  );
  swie_div #(.NW(DIV2_NW), .DW(DIV2_DW)) u_div_lpos (
    .clk(clk), .en(en), .num_i(NUM_POS), .den_i(c_den_r), .quo_o(q_lpos)
  );

  sb2_t s2_r   [DIV2_NW];
  sb2_t s2_nxt [DIV2_NW];
  logic v2_r   [DIV2_NW];

  always_comb begin
    s2_nxt[0] = c_sb_r;
    for (int i = 1; i < DIV2_NW; i++) begin
      s2_nxt[i] = s2_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV2_NW; i++) begin
        v2_r[i] <= 1'b0;
      end
    end else if (en) begin
      v2_r[0] <= c_v_r;
      for (int i = 1; i < DIV2_NW; i++) begin
        v2_r[i] <= v2_r[i-1];
      end
    end
  end

  // row assembly
  sb2_t      tail_sb;
  logic      tail_v;
  out_beat_t rows_nxt [NCOMP];

  assign tail_sb = s2_r[DIV2_NW-1];
  assign tail_v  = v2_r[DIV2_NW-1];

  always_comb begin
    logic               deg;
    logic signed [31:0] l0, lnc, ltc, r0v, rnc, rtc;
    deg = tail_sb.degc | tail_sb.sat | q_l00.ovf | q_l20.ovf | q_lneg.ovf | q_lpos.ovf;
    for (int k = 0; k < NCOMP; k++) begin
      if (k == 0) begin
        l0  = q_l00.val;
        lnc = q_lneg.val;
        ltc = '0;
        r0v = ONE_Q;
        rnc = tail_sb.r0nc;
        rtc = (SPACE_DIMS >= 2) ? tail_sb.ut : '0;
        rows_nxt[k].lambda_center = tail_sb.lm[ST_C];
        rows_nxt[k].lambda_left   = tail_sb.lm[ST_L];
        rows_nxt[k].lambda_right  = tail_sb.lm[ST_R];
      end else if (k == NCOMP - 1) begin
        l0  = q_l20.val;
        lnc = q_lpos.val;
        ltc = '0;
        r0v = ONE_Q;
        rnc = tail_sb.r2nc;
        rtc = (SPACE_DIMS >= 2) ? tail_sb.ut : '0;
        rows_nxt[k].lambda_center = tail_sb.lp[ST_C];
        rows_nxt[k].lambda_left   = tail_sb.lp[ST_L];
        rows_nxt[k].lambda_right  = tail_sb.lp[ST_R];
      end else begin
        l0  = tail_sb.l10;
        lnc = '0;
        ltc = ONE_Q;
        r0v = '0;
        rnc = '0;
        rtc = ONE_Q;
        rows_nxt[k].lambda_center = tail_sb.uu[ST_C];
        rows_nxt[k].lambda_left   = tail_sb.uu[ST_L];
        rows_nxt[k].lambda_right  = tail_sb.uu[ST_R];
      end
      if (tail_sb.degc) begin
        l0  = '0;
        lnc = '0;
        ltc = '0;
        r0v = '0;
        rnc = '0;
        rtc = '0;
      end
      rows_nxt[k].l_col0     = l0;
      rows_nxt[k].l_col1     = tail_sb.axis ? ltc : lnc;
      rows_nxt[k].l_col2     = tail_sb.axis ? lnc : ltc;
      rows_nxt[k].r_col0     = r0v;
      rows_nxt[k].r_col1     = tail_sb.axis ? rtc : rnc;
      rows_nxt[k].r_col2     = tail_sb.axis ? rnc : rtc;
      rows_nxt[k].hyperbolic = tail_sb.hyp;
      rows_nxt[k].degenerate = deg;
      rows_nxt[k].last_row   = (k == NCOMP - 1);
    end
  end

  // row buffer: one row per beat
  out_beat_t        rows_r [NCOMP];
  logic             buf_v_r, buf_v_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             last_out, buf_free;

  assign last_out  = (row_r == LAST_ROW);
  assign buf_free  = !buf_v_r || (out_ready && last_out);
  assign en        = buf_free || !tail_v;
  assign in_ready  = en;
  assign out_valid = buf_v_r;
  assign out_data  = rows_r[row_r];

  always_comb begin
    buf_v_nxt = buf_v_r;
    row_nxt   = row_r;
    if (en && tail_v) begin
      buf_v_nxt = 1'b1;
      row_nxt   = '0;
    end else if (buf_v_r && out_ready) begin
      if (last_out) begin
        buf_v_nxt = 1'b0;
        row_nxt   = '0;
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      row_r   <= '0;
    end else begin
      buf_v_r <= buf_v_nxt;
      row_r   <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && tail_v) begin
      rows_r <= rows_nxt;
    end
  end

  // checks
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= LAST_ROW)
    else $error("row index beyond last row");

  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> row_r == '0)
    else $error("item did not start at its first row");

  a_rows_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_row |=> out_valid)
    else $error("rows of an item dropped");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_row == (row_r == LAST_ROW)))
    else $error("last_row flag out of step with row index");

  a_r_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (row_r == '0) && !out_data.degenerate |-> out_data.r_col0 == ONE_Q)
    else $error("first right eigenvector row lost its depth entry");

endmodule

FILE: hdl/swie_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swie_div
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero and saturating the quotient to 32 bits; stages advance only on en.
// ----------------------------------------------------------------------------
module swie_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  output swie_pkg::sat_t       quo_o
);
  import swie_pkg::*;

  logic [DW-1:0] rem_r   [NW];
  logic [DW-1:0] rem_nxt [NW];
  logic [NW-1:0] nq_r    [NW];
  logic [NW-1:0] nq_nxt  [NW];
  logic [DW-1:0] dm_r    [NW];
  logic [DW-1:0] dm_nxt  [NW];
  logic          neg_r   [NW];
  logic          neg_nxt [NW];
  logic          nneg_r  [NW];
  logic          nneg_nxt[NW];
  logic          nz_r    [NW];
  logic          nz_nxt  [NW];
  logic          dz_r    [NW];
  logic          dz_nxt  [NW];

  logic [NW-1:0]      nmag;
  logic [DW-1:0]      dmag;
  logic [NW-1:0]      q;
  logic signed [NW:0] qs;
  logic               fits;

  always_comb begin
    logic [DW:0] trial;
    nmag  = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    dmag  = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    trial = {{DW{1'b0}}, nmag[NW-1]};
    if (trial >= {1'b0, dmag}) begin
      rem_nxt[0] = DW'(trial - {1'b0, dmag});
      nq_nxt[0]  = {nmag[NW-2:0], 1'b1};
    end else begin
      rem_nxt[0] = trial[DW-1:0];
      nq_nxt[0]  = {nmag[NW-2:0], 1'b0};
    end
    dm_nxt[0]   = dmag;
    neg_nxt[0]  = num_i[NW-1] ^ den_i[DW-1];
    nneg_nxt[0] = num_i[NW-1];
    nz_nxt[0]   = |num_i;
    dz_nxt[0]   = ~|den_i;
    for (int i = 1; i < NW; i++) begin
      trial = {rem_r[i-1], nq_r[i-1][NW-1]};
      if (trial >= {1'b0, dm_r[i-1]}) begin
        rem_nxt[i] = DW'(trial - {1'b0, dm_r[i-1]});
        nq_nxt[i]  = {nq_r[i-1][NW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial[DW-1:0];
        nq_nxt[i]  = {nq_r[i-1][NW-2:0], 1'b0};
      end
      dm_nxt[i]   = dm_r[i-1];
      neg_nxt[i]  = neg_r[i-1];
      nneg_nxt[i] = nneg_r[i-1];
      nz_nxt[i]   = nz_r[i-1];
      dz_nxt[i]   = dz_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      nq_r   <= nq_nxt;
      dm_r   <= dm_nxt;
      neg_r  <= neg_nxt;
      nneg_r <= nneg_nxt;
      nz_r   <= nz_nxt;
      dz_r   <= dz_nxt;
    end
  end

  always_comb begin
    q    = nq_r[NW-1];
    qs   = neg_r[NW-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    fits = (qs[NW:31] == '0) || (qs[NW:31] == '1);
    if (dz_r[NW-1]) begin
      quo_o.ovf = 1'b1;
      quo_o.val = nneg_r[NW-1] ? S32_MIN : (nz_r[NW-1] ? S32_MAX : '0);
    end else begin
      quo_o.ovf = !fits;
      quo_o.val = fits ? qs[31:0] : (qs[NW] ? S32_MIN : S32_MAX);
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives interface cell pairs into the shallow-water eigensystem block and
// checks every characteristic row against an in-bench fixed-point predictor,
// over several gravity and flow-axis settings, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_top;
  import swie_pkg::*;

  localparam int PIPE_LAT = 110;

  class eigen_scoreboard;
    out_beat_t         pending_rows[$];
    longint unsigned   grav;
    bit                axis;
    bit                sat;
    int                fails;

    function new();
      grav  = 642908;
      axis  = 0;
      fails = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        sat = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint avg_floor(longint s);
      return (s - (s & 1)) / 2;
    endfunction

    function longint fdiv(longint num, longint den);
      if (den == 0) begin
        sat = 1;
        return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
      end
      return clamp32(num / den);
    endfunction

    function longint wave_speed(longint h);
      longint unsigned x, res, b;
      if (h <= 0) return 0;
      x   = grav * longint'(h);
      res = 0;
      b   = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x   = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function longint row_speed(longint u, longint c, bit neg, int k);
      if (neg) return u;
      if (k == 0) return clamp32(u - c);
      if (k == 2) return clamp32(u + c);
      return u;
    endfunction

    function void note_input(in_beat_t b);
      longint lh, lmx, lmy, rh, rmx, rmy, ch, cn, ct, un, ut, ul, ur, cc, cl, cr;
      longint l[3][3], r[3][3], lam[3][3];
      int nc, tc;
      bit hyp, degc;
      out_beat_t o;
      sat = 0;
      lh  = b.left_depth;       lmx = b.left_momentum_x;  lmy = b.left_momentum_y;
      rh  = b.right_depth;      rmx = b.right_momentum_x; rmy = b.right_momentum_y;
      nc  = 1 + axis;
      tc  = 2 - axis;
      ch  = avg_floor(lh + rh);
      cn  = axis ? avg_floor(lmy + rmy) : avg_floor(lmx + rmx);
      ct  = axis ? avg_floor(lmx + rmx) : avg_floor(lmy + rmy);
      ul  = fdiv((axis ? lmy : lmx) * 65536, lh);
      ur  = fdiv((axis ? rmy : rmx) * 65536, rh);
      un  = fdiv(cn * 65536, ch);
      ut  = fdiv(ct * 65536, ch);
      hyp = !(lh < 0 || rh < 0 || ch < 0);
      cl  = wave_speed(lh);
      cr  = wave_speed(rh);
      cc  = wave_speed(ch);
      degc = (ch <= 0) || (cc == 0);
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          l[k][j] = 0;
          r[k][j] = 0;
        end
        lam[k][0] = row_speed(un, cc, ch < 0, k);
        lam[k][1] = row_speed(ul, cl, lh < 0, k);
        lam[k][2] = row_speed(ur, cr, rh < 0, k);
      end
      if (!degc) begin
        l[0][0]  = fdiv((un + cc) * 65536, 2 * cc);
        l[0][nc] = fdiv(-64'sd4294967296, 2 * cc);
        l[2][0]  = fdiv(-(un - cc) * 65536, 2 * cc);
        l[2][nc] = fdiv(64'sd4294967296, 2 * cc);
        r[0][0]  = 65536;
        r[0][nc] = clamp32(un - cc);
        r[2][0]  = 65536;
        r[2][nc] = clamp32(un + cc);
        r[0][tc] = ut;
        r[2][tc] = ut;
        l[1][0]  = clamp32(-ut);
        l[1][tc] = 65536;
        r[1][tc] = 65536;
      end
      for (int k = 0; k < 3; k++) begin
        o.l_col0        = l[k][0][31:0];
        o.l_col1        = l[k][1][31:0];
        o.l_col2        = l[k][2][31:0];
        o.r_col0        = r[k][0][31:0];
        o.r_col1        = r[k][1][31:0];
        o.r_col2        = r[k][2][31:0];
        o.lambda_center = lam[k][0][31:0];
        o.lambda_left   = lam[k][1][31:0];
        o.lambda_right  = lam[k][2][31:0];
        o.hyperbolic    = hyp;
        o.degenerate    = degc || sat;
        o.last_row      = (k == 2);
        pending_rows.push_back(o);
      end
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        fails++;
      end
    endfunction

    function void check_row(out_beat_t a);
      out_beat_t e;
      if (pending_rows.size() == 0) begin
        $error("unexpected row: %h", a);
        fails++;
        return;
      end
      e = pending_rows.pop_front();
      cmp("l_col0", e.l_col0, a.l_col0);
      cmp("l_col1", e.l_col1, a.l_col1);
      cmp("l_col2", e.l_col2, a.l_col2);
      cmp("r_col0", e.r_col0, a.r_col0);
      cmp("r_col1", e.r_col1, a.r_col1);
      cmp("r_col2", e.r_col2, a.r_col2);
      cmp("lambda_center", e.lambda_center, a.lambda_center);
      cmp("lambda_left", e.lambda_left, a.lambda_left);
      cmp("lambda_right", e.lambda_right, a.lambda_right);
      cmp("hyperbolic", e.hyperbolic, a.hyperbolic);
      cmp("degenerate", e.degenerate, a.degenerate);
      cmp("last_row", e.last_row, a.last_row);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_beat_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_beat_t         out_data;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_addr;
  logic [CFG_W-1:0]  cfg_wdata;

  eigen_scoreboard sb = new();
  int send_idle;
  int recv_idle;
  bit hold_req;
  int hold_left;

  shallow_water_interface_eigensystem dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_row(out_data);
  end

  task automatic send_beat(in_beat_t x);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.note_input(x);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_reg(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_GRAVITY) sb.grav = v;
    else sb.axis = v[0];
  endtask

  function automatic in_beat_t cells(int lh, int lmx, int lmy, int rh, int rmx, int rmy);
    in_beat_t b;
    b.left_depth  = lh;  b.left_momentum_x  = lmx; b.left_momentum_y  = lmy;
    b.right_depth = rh;  b.right_momentum_x = rmx; b.right_momentum_y = rmy;
    return b;
  endfunction

  function automatic int rand_depth();
    return $urandom_range(6553600, 655);
  endfunction

  function automatic int rand_mom();
    return int'($urandom_range(1310720)) - 655360;
  endfunction

  function automatic in_beat_t rand_pair();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return cells(rand_depth(), rand_mom(), rand_mom(), rand_depth(), rand_mom(), rand_mom());
    if (r < 85)
      return cells(int'($urandom_range(200)) - 100, rand_mom(), rand_mom(),
                   rand_depth() - 3276800, rand_mom(), rand_mom());
    return cells($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      send_beat(rand_pair());
      if (i == n / 2) begin
        hold_req = 1;
        repeat (3) send_beat(rand_pair());
      end
    end
  endtask

  initial begin
    int maxi, mini;
    maxi      = 32'h7FFF_FFFF;
    mini      = 32'h8000_0000;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    out_ready = 1'b0;
    hold_req  = 0;
    hold_left = 0;
    send_idle = 10;
    recv_idle = 66;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_beat(cells(65536, 32768, -16384, 65536, 32768, -16384));
    send_beat(cells(0, 0, 0, 0, 0, 0));
    send_beat(cells(0, 65536, -65536, 0, -65536, 65536));
    send_beat(cells(0, 100, 0, 65536, 0, 0));
    send_beat(cells(0, -100, 0, 65536, 0, 0));
    send_beat(cells(-65536, 65536, 0, 131072, 0, 0));
    send_beat(cells(131072, 0, 0, -65536, 65536, 0));
    send_beat(cells(-65536, 0, 0, -65536, 0, 0));
    send_beat(cells(-3, 0, 0, 1, 0, 0));
    send_beat(cells(maxi, maxi, maxi, maxi, maxi, maxi));
    send_beat(cells(mini, mini, mini, mini, mini, mini));
    send_beat(cells(maxi, mini, maxi, maxi, maxi, mini));
    send_beat(cells(1, maxi, mini, 1, mini, maxi));
    send_beat(cells(1, 1, 1, 2, 1, 1));
    send_beat(cells(655360, maxi, 0, 655360, maxi, 0));
    send_beat(cells(65536, 0, 0, 65536, 0, 0));
    random_phase(20);
    drain();

    write_reg(REG_FLOW_AXIS, 1);
    send_beat(cells(65536, 32768, -16384, 65536, 32768, -16384));
    send_beat(cells(maxi, mini, maxi, maxi, maxi, mini));
    random_phase(15);
    write_reg(REG_GRAVITY, 31'h7FFF_FFFF);
    send_idle = 66;
    recv_idle = 10;
    send_beat(cells(maxi, 0, 0, maxi, 0, 0));
    random_phase(15);
    write_reg(REG_GRAVITY, 0);
    send_beat(cells(65536, 32768, 0, 65536, 0, 0));
    random_phase(10);
    write_reg(REG_FLOW_AXIS, 0);
    random_phase(15);
    write_reg(REG_GRAVITY, 1);
    send_idle = 0;
    recv_idle = 0;
    random_phase(15);
    write_reg(REG_GRAVITY, 642908);
    random_phase(25);

    drain();
    if (sb.pending_rows.size() != 0) sb.fails++;
    if (sb.fails == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
